// ===== rtl/extending_integer_alu_core_assert.svh =====
// Assertion macros shared by the ALU core.
`ifndef EXTENDING_INTEGER_ALU_CORE_ASSERT_SVH
`define EXTENDING_INTEGER_ALU_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, disabled in reset.
`define EIA_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked on clk, disabled in reset.
`define EIA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/eia_pkg.sv =====
// Types, codes and operand extension helpers for the extending integer ALU.
package eia_pkg;

	// Largest declared operand width the datapath honors
	localparam logic [6:0] MAX_WIDTH = 7'd64;

	typedef enum logic [3:0] {
		KIND_ADD  = 4'd0,
		KIND_SUB  = 4'd1,
		KIND_MUL  = 4'd2,
		KIND_MIN  = 4'd3,
		KIND_MAX  = 4'd4,
		KIND_NOT  = 4'd5,
		KIND_AND  = 4'd6,
		KIND_OR   = 4'd7,
		KIND_XOR  = 4'd8,
		KIND_SHL  = 4'd9,
		KIND_SHR  = 4'd10,
		KIND_SHRU = 4'd11,
		KIND_MOVE = 4'd12,
		KIND_SEL  = 4'd13,
		KIND_CMP  = 4'd14
	} kind_t;

	typedef enum logic [3:0] {
		CMP_NE   = 4'd0,
		CMP_EQ   = 4'd1,
		CMP_LE   = 4'd2,
		CMP_LEU  = 4'd3,
		CMP_LT   = 4'd4,
		CMP_LTU  = 4'd5,
		CMP_GT   = 4'd6,
		CMP_GTU  = 4'd7,
		CMP_GE   = 4'd8,
		CMP_GEU  = 4'd9,
		CMP_ANDL = 4'd10,
		CMP_NAND = 4'd11,
		CMP_ORL  = 4'd12,
		CMP_NORL = 4'd13
	} cmp_t;

	// Select variants: pick A on a true or on a false condition
	localparam logic [3:0] SEL_IF_TRUE  = 4'd0;
	localparam logic [3:0] SEL_IF_FALSE = 4'd1;

	// Extension modes; code 3 behaves as zero extension
	localparam logic [1:0] EXT_ZERO   = 2'd0;
	localparam logic [1:0] EXT_SIGN   = 2'd1;
	localparam logic [1:0] EXT_NEGLIT = 2'd2;

	function automatic logic [6:0] clamp_width(input logic [6:0] w);
		return (w > MAX_WIDTH) ? MAX_WIDTH : w;
	endfunction

	function automatic logic [63:0] low_mask(input logic [6:0] bits);
		logic [63:0] m;
		if (bits == 7'd0) begin
			m = '0;
		end else if (bits >= 7'd64) begin
			m = '1;
		end else begin
			m = ~({64{1'b1}} << bits[5:0]);
		end
		return m;
	endfunction

	// Bring a raw operand to its declared width and fill the upper bits
	function automatic logic [63:0] extend_op(input logic [63:0] raw,
			input logic [6:0] wfield, input logic [1:0] mode);
		logic [6:0]  bits;
		logic [63:0] m;
		logic [63:0] v;
		logic [5:0]  top;
		logic        sgn;
		bits = clamp_width(wfield);
		m    = low_mask(bits);
		v    = raw & m;
		top  = 6'(bits - 7'd1);
		sgn  = 1'b0;
		if (mode == EXT_SIGN) begin
			sgn = raw[top];
		end else if (mode == EXT_NEGLIT) begin
			sgn = raw[63];
		end
		if (bits == 7'd0) begin
			v = '0;
		end else if (bits < 7'd64 && sgn) begin
			v = v | ~m;
		end
		return v;
	endfunction

endpackage

// ===== rtl/extending_integer_alu_core.sv =====
// Three-stage pipelined 64-bit integer ALU with operand width extension.
//
// Usage: drive an operation and its operands and raise start for one cycle;
// the item is taken at that clock edge (busy is always low, so an item may
// be issued in every cycle). Stage 1 extends A, B and the condition to their
// declared widths and checks the shift amount range; stage 2 runs the adder,
// comparators, logic, barrel shifter and three 32x32 partial products;
// stage 3 sums the partial products for multiply and picks the result.
// Output: the item passes the stage 1, stage 2 and stage 3 registers, then the
// result sits on the result port with done high for exactly one cycle.
// Throughput: one item per cycle, sustained; every stage advances on every
// edge and nothing feeds back.
// Items leave in the order they were issued.
// Reset: arst_n low clears all stage valid bits at once; items in flight are
// dropped and done stays low until new items arrive.
// The receiver cannot stall: every result must be captured in its done cycle.
`include "extending_integer_alu_core_assert.svh"

module extending_integer_alu_core
	import eia_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  kind,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	input  logic [6:0]  a_width,
	input  logic [6:0]  b_width,
	input  logic [1:0]  a_ext,
	input  logic [1:0]  b_ext,
	input  logic [63:0] cond_raw,
	input  logic [6:0]  cond_width,
	input  logic [1:0]  cond_ext,
	input  logic [3:0]  variant,
	output logic [63:0] result,
	output logic        done
);

	// Stage 1 registers
	logic        v_s1;
	kind_t       kind_s1;
	logic [3:0]  variant_s1;
	logic [63:0] a_s1;
	logic [63:0] b_s1;
	logic        c_nz_s1;
	logic        a_signed_s1;
	logic        in_range_s1;

	// Stage 2 registers
	logic        v_s2;
	logic [63:0] r_s2;
	logic [63:0] p_ll_s2;
	logic [31:0] p_lh_s2;
	logic [31:0] p_hl_s2;
	logic        mul_s2;
	logic        cmp_s2;

	// Stage 3 registers
	logic        v_s3;
	logic [63:0] r_s3;
	logic        cmp_s3;

	logic        accept;
	logic [63:0] a_ext_val;
	logic [63:0] b_ext_val;
	logic [63:0] c_ext_val;
	logic [63:0] r_d;
	logic [63:0] mul_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Extend operands
	assign a_ext_val = extend_op(op_a, a_width, a_ext);
	assign b_ext_val = extend_op(op_b, b_width, b_ext);
	assign c_ext_val = extend_op(cond_raw, cond_width, cond_ext);

	// Advance stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Capture extended operands
	always_ff @(posedge clk) begin
		kind_s1     <= kind_t'(kind);
		variant_s1  <= variant;
		a_s1        <= a_ext_val;
		b_s1        <= b_ext_val;
		c_nz_s1     <= (c_ext_val != 64'd0);
		a_signed_s1 <= (a_ext == EXT_SIGN) || (a_ext == EXT_NEGLIT);
		in_range_s1 <= (b_ext_val <= low_mask(clamp_width(b_width)));
	end

	// Compute every operation but the multiply sum
	always_comb begin
		logic        a_neg;
		logic [63:0] fill;
		logic        eq;
		logic        ult;
		logic        slt;
		logic        big;
		logic        a_lt;
		logic [63:0] sra;
		a_neg = a_s1[63];
		fill  = {64{a_neg}};
		eq    = (a_s1 == b_s1);
		ult   = (a_s1 < b_s1);
		slt   = ($signed(a_s1) < $signed(b_s1));
		big   = (b_s1 >= 64'd64);
		a_lt  = a_signed_s1 ? slt : ult;
		sra   = $signed(a_s1) >>> b_s1[5:0];
		r_d   = '0;
		case (kind_s1)
			KIND_ADD:  r_d = a_s1 + b_s1;
			KIND_SUB:  r_d = a_s1 - b_s1;
			KIND_MUL:  r_d = '0;
			KIND_MIN:  r_d = a_lt ? a_s1 : b_s1;
			KIND_MAX:  r_d = (!a_lt && !eq) ? a_s1 : b_s1;
			KIND_NOT:  r_d = ~a_s1;
			KIND_AND:  r_d = a_s1 & b_s1;
			KIND_OR:   r_d = a_s1 | b_s1;
			KIND_XOR:  r_d = a_s1 ^ b_s1;
			KIND_SHL: begin
				r_d = (!in_range_s1 || big) ? 64'd0 : (a_s1 << b_s1[5:0]);
			end
			KIND_SHR: begin
				r_d = (!in_range_s1 || big) ? fill : sra;
			end
			KIND_SHRU: begin
				if (!in_range_s1) begin
					r_d = fill;
				end else if (big) begin
					r_d = '0;
				end else begin
					r_d = a_s1 >> b_s1[5:0];
				end
			end
			KIND_MOVE: r_d = a_s1;
			KIND_SEL: begin
				if ((variant_s1 == SEL_IF_TRUE && c_nz_s1) ||
						(variant_s1 == SEL_IF_FALSE && !c_nz_s1)) begin
					r_d = a_s1;
				end else begin
					r_d = b_s1;
				end
			end
			KIND_CMP: begin
				case (cmp_t'(variant_s1))
					CMP_NE:   r_d = {63'd0, !eq};
					CMP_EQ:   r_d = {63'd0, eq};
					CMP_LE:   r_d = {63'd0, slt || eq};
					CMP_LEU:  r_d = {63'd0, ult || eq};
					CMP_LT:   r_d = {63'd0, slt};
					CMP_LTU:  r_d = {63'd0, ult};
					CMP_GT:   r_d = {63'd0, !slt && !eq};
					CMP_GTU:  r_d = {63'd0, !ult && !eq};
					CMP_GE:   r_d = {63'd0, !slt};
					CMP_GEU:  r_d = {63'd0, !ult};
					CMP_ANDL: r_d = {63'd0, (a_s1 != 64'd0) && (b_s1 != 64'd0)};
					CMP_NAND: r_d = {63'd0, (a_s1 == 64'd0) || (b_s1 == 64'd0)};
					CMP_ORL:  r_d = {63'd0, (a_s1 != 64'd0) || (b_s1 != 64'd0)};
					CMP_NORL: r_d = {63'd0, (a_s1 == 64'd0) && (b_s1 == 64'd0)};
					default:  r_d = '0;
				endcase
			end
			default:   r_d = '0;
		endcase
	end

	// Hold results and 32x32 partial products
	always_ff @(posedge clk) begin
		r_s2    <= r_d;
		p_ll_s2 <= a_s1[31:0] * b_s1[31:0];
		p_lh_s2 <= 32'(a_s1[31:0] * b_s1[63:32]);
		p_hl_s2 <= 32'(a_s1[63:32] * b_s1[31:0]);
		mul_s2  <= (kind_s1 == KIND_MUL);
		cmp_s2  <= (kind_s1 == KIND_CMP);
	end

	// Sum partial products for the low 64 bits of the product
	assign mul_d = p_ll_s2 + {p_lh_s2 + p_hl_s2, 32'd0};

	always_ff @(posedge clk) begin
		r_s3   <= mul_s2 ? mul_d : r_s2;
		cmp_s3 <= cmp_s2;
	end

	assign result = r_s3;
	assign done   = v_s3;

	`EIA_ASSERT_NEXT(a_accept_enters, accept, v_s1, "accepted item did not enter stage 1")
	`EIA_ASSERT_NEXT(a_s1_advances, v_s1, v_s2, "stage 1 item did not advance")
	`EIA_ASSERT_NEXT(a_s2_delivers, v_s2, done, "stage 2 item was not delivered")
	`EIA_ASSERT_IMPL(a_cmp_bool, done && cmp_s3, result[63:1] == 63'd0, "compare not 0 or 1")

endmodule
